// ===== hdl/esd_pkg.sv =====
package esd_pkg;

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESCAPE,
        MODE_HEX_HI,
        MODE_HEX_LO
    } t_mode;

    typedef logic [7:0] t_byte;

    localparam t_byte CH_BACKSLASH = 8'h5C;
    localparam t_byte CH_X         = 8'h78;
    localparam t_byte CH_A_LOWER   = 8'h61;
    localparam t_byte CH_B_LOWER   = 8'h62;
    localparam t_byte CH_T_LOWER   = 8'h74;
    localparam t_byte CH_N_LOWER   = 8'h6E;
    localparam t_byte CH_V_LOWER   = 8'h76;
    localparam t_byte CH_F_LOWER   = 8'h66;
    localparam t_byte CH_R_LOWER   = 8'h72;
    localparam t_byte CH_ZERO      = 8'h30;
    localparam t_byte CH_A_UPPER   = 8'h41;

    localparam t_byte CC_BEL = 8'h07;
    localparam t_byte CC_BS  = 8'h08;
    localparam t_byte CC_HT  = 8'h09;
    localparam t_byte CC_LF  = 8'h0A;
    localparam t_byte CC_VT  = 8'h0B;
    localparam t_byte CC_FF  = 8'h0C;
    localparam t_byte CC_CR  = 8'h0D;

    // hex digit value, anything else counts as zero
    function automatic logic [3:0] hex_value(input t_byte c);
        logic [3:0] v;
        v = 4'd0;
        case (c) inside
            [8'h30:8'h39]: v = c[3:0];
            [8'h41:8'h46],
            [8'h61:8'h66]: v = c[3:0] + 4'd9;
            default:       v = 4'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/esd_stream_if.sv =====
interface esd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface esd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== hdl/escape_sequence_decoder_unit.sv =====
// Backslash escape decoder for a byte stream. Each input transaction carries
// one character and a flag on the final character of a string; \a \b \t \n
// \v \f \r and a doubled backslash become one byte, \x with two following
// characters becomes one hex byte (non-hex digits count as 0), an unknown
// escape passes both characters through. A character yields zero to three
// output bytes, delivered in order, the last byte of a string flagged.
// Rate: one input transaction per cycle while each yields at most one byte
// and the output is ready; a character that yields two or three bytes
// occupies the three-byte result register, and the input stalls until its
// final byte is taken. Input ready follows output ready combinationally
// on that final byte; the first output byte follows in the next cycle.
module escape_sequence_decoder_unit
    import esd_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    esd_in_if.sink    i_in,
    esd_out_if.source o_out
);

    // decode state
    t_mode r_mode;
    t_mode n_mode;
    t_byte r_hex_hi;

    // result register: up to three bytes, drained from entry 0
    t_byte      r_bytes [3];
    logic [1:0] r_cnt;
    logic       r_last;

    // group built from the current input
    t_byte      n_bytes [3];
    logic [1:0] n_cnt;

    t_byte c;
    logic  last;
    logic  take;
    logic  slot_free;
    logic  acc;

    assign c    = i_in.in_byte;
    assign last = i_in.in_last;

    assign take      = (r_cnt != 2'd0) && o_out.ready;
    assign slot_free = (r_cnt == 2'd0) || (take && r_cnt == 2'd1);
    assign acc       = i_in.valid && slot_free;

    assign i_in.ready     = slot_free;
    assign o_out.valid    = (r_cnt != 2'd0);
    assign o_out.out_byte = r_bytes[0];
    assign o_out.out_last = r_last && (r_cnt == 2'd1);

    // next decode mode; end of string always returns to plain text
    always_comb begin
        n_mode = r_mode;
        case (r_mode)
            MODE_PLAIN: begin
                if (c == CH_BACKSLASH) n_mode = MODE_ESCAPE;
            end
            MODE_ESCAPE: begin
                n_mode = (c == CH_X) ? MODE_HEX_HI : MODE_PLAIN;
            end
            MODE_HEX_HI: n_mode = MODE_HEX_LO;
            MODE_HEX_LO: n_mode = MODE_PLAIN;
            default:     n_mode = MODE_PLAIN;
        endcase
        if (last) n_mode = MODE_PLAIN;
    end

    // output group for the current character
    always_comb begin
        n_bytes[0] = c;
        n_bytes[1] = c;
        n_bytes[2] = c;
        n_cnt      = 2'd0;
        case (r_mode)
            MODE_PLAIN: begin
                n_cnt = (c == CH_BACKSLASH && !last) ? 2'd0 : 2'd1;
            end
            MODE_ESCAPE: begin
                n_cnt = 2'd1;
                case (c)
                    CH_A_LOWER:   n_bytes[0] = CC_BEL;
                    CH_B_LOWER:   n_bytes[0] = CC_BS;
                    CH_T_LOWER:   n_bytes[0] = CC_HT;
                    CH_N_LOWER:   n_bytes[0] = CC_LF;
                    CH_V_LOWER:   n_bytes[0] = CC_VT;
                    CH_F_LOWER:   n_bytes[0] = CC_FF;
                    CH_R_LOWER:   n_bytes[0] = CC_CR;
                    CH_BACKSLASH: n_bytes[0] = CH_BACKSLASH;
                    CH_X: begin
                        n_bytes[0] = CH_BACKSLASH;
                        n_cnt      = last ? 2'd2 : 2'd0;
                    end
                    default: begin
                        // unknown escape: backslash then the character
                        n_bytes[0] = CH_BACKSLASH;
                        n_cnt      = 2'd2;
                    end
                endcase
            end
            MODE_HEX_HI: begin
                // string ends after \x and one more byte
                n_bytes[0] = CH_BACKSLASH;
                n_bytes[1] = CH_X;
                n_cnt      = last ? 2'd3 : 2'd0;
            end
            MODE_HEX_LO: begin
                n_bytes[0] = {hex_value(r_hex_hi), hex_value(c)};
                n_cnt      = 2'd1;
            end
            default: n_cnt = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_cnt    <= 2'd0;
            r_hex_hi <= '0;
        end else begin
            if (acc) r_mode <= n_mode;
            if (acc && r_mode == MODE_HEX_HI && !last) r_hex_hi <= c;
            if (acc && n_cnt != 2'd0) begin
                r_cnt <= n_cnt;
            end else if (take) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && n_cnt != 2'd0) begin
            r_bytes[0] <= n_bytes[0];
            r_bytes[1] <= n_bytes[1];
            r_bytes[2] <= n_bytes[2];
            r_last     <= last;
        end else if (take) begin
            r_bytes[0] <= r_bytes[1];
            r_bytes[1] <= r_bytes[2];
        end
    end

    // end of string always leaves plain text behind
    a_last_resets_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && last |=> r_mode == MODE_PLAIN)
        else $error("mode not plain after final character");

    // a final character always produces a flagged group
    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && last |=> r_cnt != 2'd0 && r_last)
        else $error("final character produced no flagged output");

    // low hex digit gives exactly one byte
    a_hex_lo_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && r_mode == MODE_HEX_LO |=> r_cnt == 2'd1 && r_mode == MODE_PLAIN)
        else $error("hex byte not a single output");

endmodule
